// ----- src/utf8_to_utf16_console_stream_unit_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 console stream unit - assertion macros
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_CONSOLE_STREAM_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_CONSOLE_STREAM_UNIT_ASSERT_SVH

// Same-cycle implication
`define U8U16_ASSERT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define U8U16_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 console stream unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [15:0] CH_QMARK = 16'h003F;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_SPACE = 16'h0020;

  // What a finished code point expands into
  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_UNIT = 3'd1,
    K_PAIR = 3'd2,
    K_CRLF = 3'd3,
    K_TAB  = 3'd4
  } kind_t;

  // One queued job: optional leading '?' then the expansion of one code point
  typedef struct packed {
    logic        pre_q;
    kind_t       kind;
    logic [15:0] unit0;
    logic [15:0] unit1;
  } job_t;

endpackage

`default_nettype wire

// ----- src/u8u16_front.sv -----
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: tracks the UTF-8 sequence state and classifies each byte
// into a job for the expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_acc,
  input  wire  [7:0]          text_byte,
  output logic                push,
  output u8u16_pkg::job_t     job
);
  import u8u16_pkg::*;

  logic [1:0]  pending_r, pending_nxt;
  logic [20:0] acc_r, acc_nxt;

  logic        bad_cont;
  logic        emit;
  logic [20:0] cp;
  logic [20:0] acc_cont;
  logic [19:0] sv;

  always_comb begin
    pending_nxt = pending_r;
    acc_nxt     = acc_r;
    bad_cont    = 1'b0;
    emit        = 1'b0;
    cp          = '0;
    acc_cont    = {acc_r[14:0], text_byte[5:0]};
    if (text_byte == 8'h00) begin
      // terminator: ignored
    end else if (pending_r != 2'd0 && text_byte[7:6] == 2'b10) begin
      acc_nxt     = acc_cont;
      pending_nxt = pending_r - 2'd1;
      if (pending_r == 2'd1) begin
        emit = 1'b1;
        cp   = acc_cont;
      end
    end else begin
      if (pending_r != 2'd0) begin
        bad_cont    = 1'b1;
        pending_nxt = 2'd0;
        acc_nxt     = '0;
      end
      if (text_byte[7] == 1'b0) begin
        emit = 1'b1;
        cp   = {13'd0, text_byte};
      end else if ((text_byte & 8'hE0) == 8'hC0) begin
        acc_nxt     = {16'd0, text_byte[4:0]};
        pending_nxt = 2'd1;
      end else if ((text_byte & 8'hF0) == 8'hE0) begin
        acc_nxt     = {17'd0, text_byte[3:0]};
        pending_nxt = 2'd2;
      end else if ((text_byte & 8'hF8) == 8'hF0) begin
        acc_nxt     = {18'd0, text_byte[2:0]};
        pending_nxt = 2'd3;
      end else begin
        emit = 1'b1;
        cp   = {5'd0, CH_QMARK};
      end
    end
  end

  always_comb begin
    sv        = 20'(cp - 21'h010000);
    job.pre_q = bad_cont;
    job.kind  = K_NONE;
    job.unit0 = cp[15:0];
    job.unit1 = '0;
    if (emit) begin
      if (cp == 21'h00000D) begin
        job.kind = K_NONE;
      end else if (cp == 21'h00000A) begin
        job.kind = K_CRLF;
      end else if (cp == 21'h000009) begin
        job.kind = K_TAB;
      end else if (cp < 21'h000020) begin
        job.kind = K_NONE;
      end else if (cp <= 21'h00FFFF) begin
        job.kind = K_UNIT;
      end else if (cp <= 21'h10FFFF) begin
        job.kind  = K_PAIR;
        job.unit0 = {6'b110110, sv[19:10]};
        job.unit1 = {6'b110111, sv[9:0]};
      end else begin
        job.kind  = K_UNIT;
        job.unit0 = CH_QMARK;
      end
    end
    push = in_acc && (job.pre_q || job.kind != K_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
      acc_r     <= '0;
    end else if (in_acc) begin
      pending_r <= pending_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/u8u16_queue.sv -----
// ----------------------------------------------------------------------------
// u8u16_queue
// Small job FIFO between the byte decoder and the unit expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_utf16_console_stream_unit_assert.svh"

module u8u16_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  u8u16_pkg::job_t     push_job,
  input  wire                 pop,
  output logic                full,
  output logic                head_vld,
  output u8u16_pkg::job_t     head_job
);
  import u8u16_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop  ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  `U8U16_ASSERT(a_no_overflow, clk, rst_n, push, !full, "job queue overflow")
  `U8U16_ASSERT(a_no_underflow, clk, rst_n, pop, head_vld, "job queue underflow")
  `U8U16_ASSERT(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= QCNT_W'(QUEUE_DEPTH), "count range")

endmodule

`default_nettype wire

// ----- src/u8u16_back.sv -----
// ----------------------------------------------------------------------------
// u8u16_back
// Unit expander: turns queued jobs into UTF-16 code units, one per cycle
// while out_tready does not stall the output, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_to_utf16_console_stream_unit_assert.svh"

module u8u16_back #(
  parameter int TAB_SPACES = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 head_vld,
  input  u8u16_pkg::job_t     head_job,
  output logic                pop,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [15:0]         out_tdata,
  output logic                out_tlast
);
  import u8u16_pkg::*;

  localparam int CNT_W = $clog2(TAB_SPACES + 2);

  job_t             job_r, job_nxt;
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             ovld_r, ovld_nxt;
  logic [15:0]      odata_r;
  logic             olast_r;

  job_t             cur;
  logic             cur_vld;
  logic [CNT_W-1:0] n_units;
  logic [CNT_W-1:0] pre;
  logic [CNT_W-1:0] j;
  logic [15:0]      unit;
  logic             is_last;
  logic             advance;

  always_comb begin
    cur     = busy_r ? job_r : head_job;
    cur_vld = busy_r || head_vld;
    pre     = CNT_W'(cur.pre_q);
    j       = idx_r - pre;
    unique case (cur.kind)
      K_NONE:  n_units = pre;
      K_UNIT:  n_units = pre + CNT_W'(1);
      K_PAIR:  n_units = pre + CNT_W'(2);
      K_CRLF:  n_units = pre + CNT_W'(2);
      K_TAB:   n_units = pre + CNT_W'(TAB_SPACES);
      default: n_units = pre;
    endcase
    if (cur.pre_q && idx_r == '0) begin
      unit = CH_QMARK;
    end else begin
      unique case (cur.kind)
        K_UNIT:  unit = cur.unit0;
        K_PAIR:  unit = (j == '0) ? cur.unit0 : cur.unit1;
        K_CRLF:  unit = (j == '0) ? CH_CR : CH_LF;
        K_TAB:   unit = CH_SPACE;
        default: unit = CH_QMARK;
      endcase
    end
    is_last = (idx_r == n_units - CNT_W'(1));
    advance = cur_vld && (!ovld_r || out_tready);
    pop     = advance && !busy_r;

    job_nxt  = job_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ovld_nxt = out_tready ? 1'b0 : ovld_r;
    if (advance) begin
      ovld_nxt = 1'b1;
      if (is_last) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        job_nxt  = cur;
        busy_nxt = 1'b1;
        idx_nxt  = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (advance) begin
      odata_r <= unit;
      olast_r <= is_last;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  `U8U16_ASSERT(a_busy_idx, clk, rst_n, busy_r, idx_r != '0, "busy with index zero")
  `U8U16_ASSERT(a_busy_range, clk, rst_n, busy_r, idx_r < n_units, "index past job end")
  `U8U16_ASSERT_NEXT(a_adv_loads, clk, rst_n, advance, ovld_r, "advance lost a unit")

endmodule

`default_nettype wire

// ----- src/utf8_to_utf16_console_stream_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_console_stream_unit
// Streaming UTF-8 to UTF-16 console decoder: CR dropped, LF to CR LF,
// TAB to spaces, other controls dropped, surrogate pairs above 0xFFFF.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                 | tuser | tlast
// in_     | in  | [7:0] text_byte       | -     | -
// out_    | out | [15:0] code_unit      | -     | last_unit
//
// One byte accepted per cycle while the job queue has room; the expander
// emits one code unit per cycle while out_tready does not stall it, and a
// byte produces 0 to 1 + TAB_SPACES units. The first unit passes through the
// job queue and then the registered output stage. Reset (rst_n low,
// synchronous) clears decoder state, queue and output stage. Output stalls
// fill the four-entry job queue before in_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_console_stream_unit #(
  parameter int TAB_SPACES = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_unit
  output logic        out_tlast
);
  import u8u16_pkg::*;

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_vld;
  job_t  f_job;
  job_t  q_job;
  logic  in_acc;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .text_byte (in_tdata),
    .push      (q_push),
    .job       (f_job)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (f_job),
    .pop      (q_pop),
    .full     (q_full),
    .head_vld (q_vld),
    .head_job (q_job)
  );

  u8u16_back #(
    .TAB_SPACES (TAB_SPACES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (q_vld),
    .head_job   (q_job),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 console stream unit - self-checking testbench
// Feeds UTF-8 bytes in bursts while the result side stalls on its own
// pattern. A scoreboard decodes each accepted byte into the code units it
// should produce and checks every result transaction against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import u8u16_pkg::*;

  localparam int TAB_SPACES   = 4;
  localparam int RANDOM_BYTES = 140;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
  } console_unit_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKY} rx_mode_e;

  class code_unit_scoreboard;
    logic [1:0]    bytes_owed;
    logic [20:0]   cp_acc;
    logic [15:0]   step_units[$];
    console_unit_t due_units[$];
    int            units_checked;
    int            mismatches;

    function new();
      bytes_owed    = '0;
      cp_acc        = '0;
      units_checked = 0;
      mismatches    = 0;
    endfunction

    function void expand_codepoint(logic [20:0] cp);
      logic [20:0] offs;
      offs = cp - 21'h10000;
      if (cp == 21'(CH_CR)) begin
      end else if (cp == 21'(CH_LF)) begin
        step_units.push_back(CH_CR);
        step_units.push_back(CH_LF);
      end else if (cp == 21'h09) begin
        repeat (TAB_SPACES) step_units.push_back(CH_SPACE);
      end else if (cp < 21'h20) begin
      end else if (cp <= 21'hFFFF) begin
        step_units.push_back(cp[15:0]);
      end else if (cp <= 21'h10FFFF) begin
        step_units.push_back(16'hD800 + 16'(offs[19:10]));
        step_units.push_back(16'hDC00 + 16'(offs[9:0]));
      end else begin
        step_units.push_back(CH_QMARK);
      end
    endfunction

    function void decode_lead_byte(logic [7:0] b);
      if (!b[7]) begin
        expand_codepoint(21'(b));
      end else if (b[7:5] == 3'b110) begin
        cp_acc     = 21'(b[4:0]);
        bytes_owed = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc     = 21'(b[3:0]);
        bytes_owed = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc     = 21'(b[2:0]);
        bytes_owed = 2'd3;
      end else begin
        step_units.push_back(CH_QMARK);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      step_units.delete();
      if (b != 8'h00) begin
        if (bytes_owed == 2'd0) begin
          decode_lead_byte(b);
        end else if (b[7:6] == 2'b10) begin
          cp_acc     = {cp_acc[14:0], b[5:0]};
          bytes_owed = bytes_owed - 2'd1;
          if (bytes_owed == 2'd0) expand_codepoint(cp_acc);
        end else begin
          // broken sequence: flag it, then restart on this byte
          bytes_owed = '0;
          cp_acc     = '0;
          step_units.push_back(CH_QMARK);
          decode_lead_byte(b);
        end
      end
      foreach (step_units[i])
        due_units.push_back({step_units[i], i == step_units.size() - 1});
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task check_unit(logic [15:0] unit, logic last);
      console_unit_t want;
      units_checked++;
      if (due_units.size() == 0) begin
        report_mismatch($sformatf("unexpected code unit %h last %b", unit, last));
      end else begin
        want = due_units.pop_front();
        if (unit !== want.unit)
          report_mismatch($sformatf("code unit %h, want %h", unit, want.unit));
        if (last !== want.last)
          report_mismatch($sformatf("last flag %b on unit %h, want %b",
                                    last, unit, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] text_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] code_unit
  logic        out_tlast;

  code_unit_scoreboard sb = new();
  int       burst_left;
  int       bytes_sent;
  int       rx_hold;
  rx_mode_e rx_mode;

  utf8_to_utf16_console_stream_unit #(
    .TAB_SPACES(TAB_SPACES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // receiver stall pattern: the mode changes after a random hold count
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(20, 80);
    end else begin
      rx_hold--;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:   out_tready <= ((rx_hold % 16) < 4);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_unit(out_tdata, out_tlast);
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 60)
                                                : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
    bytes_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    logic [7:0] seq[$];
    int         random_sent;
    int         len;
    int         pick;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    rx_hold    = 0;
    rx_mode    = RX_OPEN;
    burst_left = 0;
    bytes_sent = 0;
    random_sent = 0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // terminator, plain ASCII, CR, LF, TAB, low control, bad leads,
    // 3- and 4-byte forms, out-of-range 4-byte form, broken sequences
    // (one ending in TAB), terminator in mid-sequence
    directed_bytes = '{8'h00, 8'h41, 8'h0D, 8'h0A, 8'h09, 8'h1F, 8'h80, 8'hFF,
                       8'hE2, 8'h82, 8'hAC,
                       8'hF0, 8'h9F, 8'h98, 8'h80,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'hC3, 8'h41,
                       8'hE2, 8'h09,
                       8'hC3, 8'h00, 8'hA9};
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    while (random_sent < RANDOM_BYTES) begin
      seq.delete();
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(1, 4);
        case (len)
          1: seq.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 31))
                                                       : 8'($urandom_range(32, 127)));
          2: seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
          3: seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
          default: seq.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        for (int i = 1; i < len; i++) begin
          if ($urandom_range(0, 11) == 0) break;
          if ($urandom_range(0, 9) == 0) seq.push_back(8'h00);
          seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end else if (pick < 9) begin
        seq.push_back(8'($urandom_range(0, 255)));
      end else begin
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
      foreach (seq[i]) begin
        send_byte(seq[i]);
        if (seq[i] != 8'h00) random_sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (sb.due_units.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d UTF-8 bytes (%0d random) and %0d code units.",
             bytes_sent, random_sent, sb.units_checked);
    $display("Mismatches seen: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule
